### sv/gc2p_pkg.sv
// ============================================================================
// gc2p_pkg: shared types, constants and functions of the polar converter
// Widths, the trig table in Q46, the pipeline item and the square-root digit.
// ============================================================================
package gc2p_pkg;

    localparam int COORD_BITS   = 10;
    localparam int CFG_BITS     = 10;
    localparam int CENTRE_BITS  = CFG_BITS - 1;
    localparam int MAG_BITS     = (COORD_BITS > CENTRE_BITS) ? COORD_BITS : CENTRE_BITS;
    localparam int SQ_BITS      = 2 * MAG_BITS;
    localparam int SUM_BITS     = SQ_BITS + 1;
    localparam int RADIUS_BITS  = COORD_BITS + 1;
    localparam int ANGLE_BITS   = 9;
    localparam int DEG_BITS     = 7;
    localparam int SEARCH_STEPS = DEG_BITS;
    localparam int PIPE_HALVES  = 2 * SEARCH_STEPS;
    localparam int ROOT_DIGITS  = MAG_BITS + 1;
    localparam int DIGITS_PER_STAGE = (ROOT_DIGITS + PIPE_HALVES - 1) / PIPE_HALVES;
    localparam int ROOT_BITS    = PIPE_HALVES * DIGITS_PER_STAGE;
    localparam int RAD_BITS     = 2 * ROOT_BITS;
    localparam int REM_BITS     = ROOT_BITS + 2;
    localparam int TRIG_FRAC    = 46;
    localparam int TRIG_BITS    = TRIG_FRAC + 1;
    localparam int TRIG_ENTRIES = 90;
    localparam int PROD_BITS    = MAG_BITS + TRIG_BITS;

    localparam logic [CFG_BITS-1:0]   GRID_RESET = CFG_BITS'(10);
    localparam logic [DEG_BITS-1:0]   DEG_LIMIT  = DEG_BITS'(TRIG_ENTRIES - 1);
    localparam logic [DEG_BITS-1:0]   DIAG_DEG   = DEG_BITS'(45);
    localparam logic [DEG_BITS-1:0]   PROBE_TOP  = DEG_BITS'(1) << (DEG_BITS - 1);
    localparam logic [ANGLE_BITS-1:0] QUAD_I_DEG   = ANGLE_BITS'(0);
    localparam logic [ANGLE_BITS-1:0] QUAD_II_DEG  = ANGLE_BITS'(90);
    localparam logic [ANGLE_BITS-1:0] QUAD_III_DEG = ANGLE_BITS'(180);
    localparam logic [ANGLE_BITS-1:0] QUAD_IV_DEG  = ANGLE_BITS'(270);
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX    = ANGLE_BITS'(359);

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } t_quad;

    typedef logic [TRIG_BITS-1:0] t_trig_tab [TRIG_ENTRIES];

    typedef struct packed {
        logic [RAD_BITS-1:0]  rad;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } t_root;

    typedef struct packed {
        logic                 zero;
        logic                 diag;
        t_quad                quad;
        logic [MAG_BITS-1:0]  u;
        logic [MAG_BITS-1:0]  v;
        logic [DEG_BITS-1:0]  deg;
        logic [DEG_BITS-1:0]  probe;
        logic                 cand_ok;
        logic [PROD_BITS-1:0] prod_v;
        logic [PROD_BITS-1:0] prod_u;
        t_root                sq;
    } t_item;

    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // rotate by one degree in Q62, round each entry to Q46
    function automatic t_trig_tab build_trig(bit want_sin);
        t_trig_tab   tab;
        logic [63:0] x1, x2, x3, x4, x5, x6, x7, x8;
        logic [63:0] s1, c1, c, s, nc, ns, w;
        x1 = PI_Q60 / 64'd45;
        x2 = mul_q62(x1, x1);
        x3 = mul_q62(x2, x1);
        x4 = mul_q62(x2, x2);
        x5 = mul_q62(x4, x1);
        x6 = mul_q62(x4, x2);
        x7 = mul_q62(x6, x1);
        x8 = mul_q62(x4, x4);
        s1 = x1 - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
        c1 = ONE_Q62 - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
        c  = ONE_Q62;
        s  = 64'd0;
        for (int k = 0; k < TRIG_ENTRIES; k++) begin
            w      = want_sin ? s : c;
            w      = (w + (64'd1 << 15)) >> 16;
            tab[k] = w[TRIG_BITS-1:0];
            nc     = mul_q62(c, c1) - mul_q62(s, s1);
            ns     = mul_q62(s, c1) + mul_q62(c, s1);
            c      = nc;
            s      = ns;
        end
        return tab;
    endfunction

    localparam t_trig_tab COS_Q46 = build_trig(1'b0);
    localparam t_trig_tab SIN_Q46 = build_trig(1'b1);

    function automatic t_root root_digit(t_root s);
        t_root               o;
        logic [REM_BITS-1:0] acc;
        logic [REM_BITS-1:0] trial;
        acc   = {s.rem[REM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
        trial = {s.root, 2'b01};
        o.rad = {s.rad[RAD_BITS-3:0], 2'b00};
        if (acc >= trial) begin
            o.rem  = acc - trial;
            o.root = {s.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            o.rem  = acc;
            o.root = {s.root[ROOT_BITS-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

### sv/grid_cartesian_to_polar_core.sv
// ============================================================================
// grid_cartesian_to_polar_core: grid cell to polar angle and radius
// The pipeline has 4 front stages, 7 two-stage degree search steps and an output register.
// Throughput is one word per cycle while the output is not stalled; the pipeline stage registers set the pace.
// Stalls collapse bubbles stage by stage, so no word is lost or repeated.
// Reset clears all valid bits and sets the grid size to 10; tables are constant.
// ============================================================================
module grid_cartesian_to_polar_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [gc2p_pkg::COORD_BITS-1:0]  i_x_coord,
    input  logic [gc2p_pkg::COORD_BITS-1:0]  i_y_coord,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [gc2p_pkg::ANGLE_BITS-1:0]  o_angle_deg,
    output logic [gc2p_pkg::RADIUS_BITS-1:0] o_radius,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gc2p_pkg::CFG_BITS-1:0]    i_cfg_data
);
    import gc2p_pkg::*;

    logic [CFG_BITS-1:0]    r_grid_size;
    logic                   front_ready;
    logic                   r_out_valid;
    logic                   out_ready;
    logic [ANGLE_BITS-1:0]  r_angle, n_angle, base;
    logic [RADIUS_BITS-1:0] r_radius;
    logic [ANGLE_BITS-1:0]  sum_deg;
    logic [DEG_BITS-1:0]    deg;

    logic  step_valid [SEARCH_STEPS+1];
    logic  step_ready [SEARCH_STEPS+1];
    t_item step_item  [SEARCH_STEPS+1];
    logic  mid_valid  [SEARCH_STEPS];
    logic  mid_ready  [SEARCH_STEPS];
    t_item mid_item   [SEARCH_STEPS];

    assign o_cfg_ready = 1'b1;
    assign o_stall     = !front_ready;
    assign o_valid     = r_out_valid;
    assign o_angle_deg = r_angle;
    assign o_radius    = r_radius;
    assign out_ready   = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_grid_size <= i_cfg_data;
        end
    end

    gc2p_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .i_centre  (r_grid_size[CFG_BITS-1:1]),
        .o_ready   (front_ready),
        .o_valid   (step_valid[0]),
        .o_item    (step_item[0]),
        .i_ready   (step_ready[0])
    );

    for (genvar s = 0; s < SEARCH_STEPS; s++) begin : g_step
        gc2p_probe u_probe (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (step_valid[s]),
            .i_item  (step_item[s]),
            .o_ready (step_ready[s]),
            .o_valid (mid_valid[s]),
            .o_item  (mid_item[s]),
            .i_ready (mid_ready[s])
        );

        gc2p_decide u_decide (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (mid_valid[s]),
            .i_item  (mid_item[s]),
            .o_ready (mid_ready[s]),
            .o_valid (step_valid[s+1]),
            .o_item  (step_item[s+1]),
            .i_ready (step_ready[s+1])
        );
    end

    assign step_ready[SEARCH_STEPS] = out_ready;

    always_comb begin
        unique case (step_item[SEARCH_STEPS].quad)
            QUAD_I:   base = QUAD_I_DEG;
            QUAD_II:  base = QUAD_II_DEG;
            QUAD_III: base = QUAD_III_DEG;
            QUAD_IV:  base = QUAD_IV_DEG;
            default:  base = QUAD_I_DEG;
        endcase
        deg     = step_item[SEARCH_STEPS].diag ? DIAG_DEG : step_item[SEARCH_STEPS].deg;
        sum_deg = base + ANGLE_BITS'(deg);
        if (step_item[SEARCH_STEPS].zero) begin
            n_angle = QUAD_I_DEG;
        end else if (sum_deg > ANGLE_MAX) begin
            n_angle = ANGLE_MAX;
        end else begin
            n_angle = sum_deg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= step_valid[SEARCH_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && step_valid[SEARCH_STEPS]) begin
            r_angle  <= n_angle;
            r_radius <= step_item[SEARCH_STEPS].sq.root[RADIUS_BITS-1:0];
        end
    end

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle_deg <= ANGLE_MAX))
        else $error("angle out of range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output drains");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_grid_size == $past(i_cfg_data)))
        else $error("grid size not written");

endmodule

### sv/gc2p_front.sv
// ============================================================================
// gc2p_front: offset, quadrant fold and squared distance
// Four stages: offset from centre, fold into first quadrant, squares, sum.
// ============================================================================
module gc2p_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [gc2p_pkg::COORD_BITS-1:0]  i_x_coord,
    input  logic [gc2p_pkg::COORD_BITS-1:0]  i_y_coord,
    input  logic [gc2p_pkg::CENTRE_BITS-1:0] i_centre,
    output logic                             o_ready,
    output logic                             o_valid,
    output gc2p_pkg::t_item                  o_item,
    input  logic                             i_ready
);
    import gc2p_pkg::*;

    typedef struct packed {
        logic                zero;
        logic                diag;
        t_quad               quad;
        logic [MAG_BITS-1:0] u;
        logic [MAG_BITS-1:0] v;
    } t_fold;

    logic                      r_v1, r_v2, r_v3, r_v4;
    logic                      rdy1, rdy2, rdy3, rdy4;
    logic signed [MAG_BITS:0]  r_dx, r_dy, n_dx, n_dy;
    logic signed [MAG_BITS:0]  neg_dx, neg_dy;
    t_fold                     r_f2, n_f2, r_f3;
    logic [SQ_BITS-1:0]        r_sq_u, r_sq_v;
    t_item                     r_item, n_item;
    logic [SUM_BITS-1:0]       sum;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;
    assign o_item  = r_item;

    always_comb begin
        n_dx = $signed({1'b0, MAG_BITS'(i_x_coord)}) - $signed({1'b0, MAG_BITS'(i_centre)});
        n_dy = $signed({1'b0, MAG_BITS'(i_y_coord)}) - $signed({1'b0, MAG_BITS'(i_centre)});
    end

    always_comb begin
        neg_dx      = -r_dx;
        neg_dy      = -r_dy;
        n_f2.zero   = (r_dx == '0) && (r_dy == '0);
        if (r_dx > 0 && r_dy >= 0) begin
            n_f2.quad = QUAD_I;
            n_f2.u    = r_dx[MAG_BITS-1:0];
            n_f2.v    = r_dy[MAG_BITS-1:0];
        end else if (r_dx <= 0 && r_dy > 0) begin
            n_f2.quad = QUAD_II;
            n_f2.u    = r_dy[MAG_BITS-1:0];
            n_f2.v    = neg_dx[MAG_BITS-1:0];
        end else if (r_dx < 0 && r_dy <= 0) begin
            n_f2.quad = QUAD_III;
            n_f2.u    = neg_dx[MAG_BITS-1:0];
            n_f2.v    = neg_dy[MAG_BITS-1:0];
        end else begin
            n_f2.quad = QUAD_IV;
            n_f2.u    = neg_dy[MAG_BITS-1:0];
            n_f2.v    = r_dx[MAG_BITS-1:0];
        end
        n_f2.diag = (n_f2.u == n_f2.v);
    end

    always_comb begin
        sum            = SUM_BITS'(r_sq_u) + SUM_BITS'(r_sq_v);
        n_item         = '0;
        n_item.zero    = r_f3.zero;
        n_item.diag    = r_f3.diag;
        n_item.quad    = r_f3.quad;
        n_item.u       = r_f3.u;
        n_item.v       = r_f3.v;
        n_item.probe   = PROBE_TOP;
        n_item.sq.rad  = RAD_BITS'(sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (rdy2 && r_v1) begin
            r_f2 <= n_f2;
        end
        if (rdy3 && r_v2) begin
            r_f3   <= r_f2;
            r_sq_u <= SQ_BITS'(r_f2.u) * SQ_BITS'(r_f2.u);
            r_sq_v <= SQ_BITS'(r_f2.v) * SQ_BITS'(r_f2.v);
        end
        if (rdy4 && r_v3) begin
            r_item <= n_item;
        end
    end

endmodule

### sv/gc2p_probe.sv
// ============================================================================
// gc2p_probe: trial degree products of one search step
// Forms v*cos and u*sin for the trial degree and advances the root digits.
// ============================================================================
module gc2p_probe (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gc2p_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output gc2p_pkg::t_item o_item,
    input  logic            i_ready
);
    import gc2p_pkg::*;

    logic                r_valid;
    t_item               r_item, n_item;
    logic [DEG_BITS-1:0] cand, idx;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item         = i_item;
        cand           = i_item.deg | i_item.probe;
        n_item.cand_ok = (cand <= DEG_LIMIT);
        idx            = n_item.cand_ok ? cand : '0;
        n_item.prod_v  = PROD_BITS'(i_item.v) * PROD_BITS'(COS_Q46[idx]);
        n_item.prod_u  = PROD_BITS'(i_item.u) * PROD_BITS'(SIN_Q46[idx]);
        for (int d = 0; d < DIGITS_PER_STAGE; d++) begin
            n_item.sq = root_digit(n_item.sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

### sv/gc2p_decide.sv
// ============================================================================
// gc2p_decide: keep or drop the trial degree of one search step
// Compares the products, sets the degree bit and advances the root digits.
// ============================================================================
module gc2p_decide (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gc2p_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output gc2p_pkg::t_item o_item,
    input  logic            i_ready
);
    import gc2p_pkg::*;

    logic  r_valid;
    t_item r_item, n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item = i_item;
        if (i_item.cand_ok && (i_item.prod_v >= i_item.prod_u)) begin
            n_item.deg = i_item.deg | i_item.probe;
        end
        n_item.probe = i_item.probe >> 1;
        for (int d = 0; d < DIGITS_PER_STAGE; d++) begin
            n_item.sq = root_digit(n_item.sq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
